// ===== rtl/sibd_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function for the
// signed integer to base digits block. No dependencies.
`default_nettype none

package sibd_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 5;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h37;  // 'A' - 10
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic load;
		logic run;
	} div_ctl_t;

	typedef struct packed {
		logic               done;
		logic               nonzero;
		logic [DIGIT_W-1:0] digit;
	} div_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] base;
		base = (d < DIGIT_TEN) ? CHAR_ZERO : CHAR_ALPHA;
		return base + CHAR_W'(d);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sibd_in_if.sv =====
// Input channel: valid/ready handshake carrying one signed value per request.
// Depends on sibd_pkg for the default width.
`default_nettype none

interface sibd_in_if #(
	parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sibd_out_if.sv =====
// Output channel: valid/ready handshake carrying one ASCII character per request.
// Depends on sibd_pkg for the character width.
`default_nettype none

interface sibd_out_if;
	logic                          valid;
	logic                          ready;
	logic [sibd_pkg::CHAR_W-1:0]   char_code;
	logic                          last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/sibd_div.sv =====
// Bit-serial restoring divider by the radix: one quotient bit per cycle,
// a digit once all VALUE_BITS bits are shifted through, quotient kept in place for the next digit.
// Depends on sibd_pkg.
`default_nettype none

module sibd_div #(
	parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sibd_pkg::div_ctl_t            ctl,
	input  logic [VALUE_BITS-1:0]         load_val,
	input  logic [sibd_pkg::RADIX_W-1:0]  radix,
	output sibd_pkg::div_sts_t            sts
);
	import sibd_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  nz_q;

	logic [RADIX_W-1:0] trial;
	logic [RADIX_W-1:0] diff;
	logic               ge;
	logic [DIGIT_W-1:0] rem_nxt;
	logic               last_bit;

	assign trial    = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge       = (trial >= radix);
	assign diff     = ge ? (trial - radix) : trial;
	assign rem_nxt  = diff[DIGIT_W-1:0];
	assign last_bit = (cnt_q == CNT_LAST);

	assign sts.done    = ctl.run && last_bit;
	assign sts.nonzero = nz_q | ge;
	assign sts.digit   = rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			nz_q  <= 1'b0;
		end else if (ctl.load) begin
			cnt_q <= '0;
			nz_q  <= 1'b0;
		end else if (ctl.run) begin
			if (last_bit) begin
				cnt_q <= '0;
				nz_q  <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				nz_q  <= nz_q | ge;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= load_val;
			rem_q <= '0;
		end else if (ctl.run) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= last_bit ? '0 : rem_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/signed_integer_to_base_digits.sv =====
// Top level: signed integer to ASCII text in a radix of 2 to 16.
// Depends on sibd_pkg, sibd_in_if, sibd_out_if and sibd_div.
//
// Usage:
//   din  : one signed VALUE_BITS value per request (valid/ready).
//   dout : one ASCII character per request, most significant first; a negative
//          value starts with '-'; last_char marks the final character.
//   cfg  : cfg_we/cfg_wdata write the radix (reset 10); 0..1 act as 2 and
//          17..31 as 16. Write only while idle.
// Timing: each digit is produced by a bit-serial divider over all VALUE_BITS bits,
//   the digits of a value one after another, then one character per cycle while
//   dout is ready.
//   Digits are held in a LIFO shift register of VALUE_BITS 4-bit entries until sent.
// One value is handled at a time; din.ready is high only when idle, which
//   starts at the edge where the last character is taken. A stalled dout
//   holds the character and pauses emission.
// Reset: asynchronous, clears control state and sets the radix to 10.
`default_nettype none

module signed_integer_to_base_digits #(
	parameter int VALUE_BITS = sibd_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sibd_in_if.sink                       din,
	sibd_out_if.source                    dout,
	input  logic                          cfg_we,
	input  logic [sibd_pkg::RADIX_W-1:0]  cfg_wdata
);
	import sibd_pkg::*;

	localparam int NDIG_W  = $clog2(VALUE_BITS + 1);
	localparam int STACK_W = VALUE_BITS * DIGIT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [RADIX_W-1:0]  radix_eff;
	logic                neg_q;
	logic [NDIG_W-1:0]   ndig_q;
	logic [STACK_W-1:0]  stack_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  emit_load;
	logic                  pop;
	div_ctl_t              div_ctl;
	div_sts_t              div_sts;

	assign radix_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
	                   (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

	assign raw = din.value;
	assign mag = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;

	assign din.ready      = (state_q == ST_IDLE);
	assign dout.valid     = out_valid_q;
	assign dout.char_code = out_char_q;
	assign dout.last_char = out_last_q;

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || dout.ready);
	assign pop       = emit_load && !neg_q && (ndig_q != '0);

	assign div_ctl.load = din.valid && din.ready;
	assign div_ctl.run  = (state_q == ST_DIV);

	sibd_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.load_val (mag),
		.radix    (radix_eff),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_RESET;
			neg_q       <= 1'b0;
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (emit_load && (neg_q || (ndig_q != '0))) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						neg_q   <= raw[VALUE_BITS-1];
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						ndig_q <= ndig_q + 1'b1;
						if (!div_sts.nonzero) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else if (ndig_q != '0) begin
							ndig_q <= ndig_q - 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit LIFO: push at the low end, most significant digit ends on top
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_sts.done) begin
			stack_q <= {stack_q[STACK_W-DIGIT_W-1:0], div_sts.digit};
		end else if (pop) begin
			stack_q <= {DIGIT_W'(0), stack_q[STACK_W-1:DIGIT_W]};
		end
		if (emit_load && neg_q) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (pop) begin
			out_char_q <= digit_char(stack_q[DIGIT_W-1:0]);
			out_last_q <= (ndig_q == NDIG_W'(1));
		end
	end

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_sts.done) |=> (ndig_q == $past(ndig_q) + 1'b1))
		else $error("digit count did not advance on digit push");

	a_ndig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= NDIG_W'(VALUE_BITS))
		else $error("digit count beyond value width");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && ndig_q == NDIG_W'(1)) |=> (dout.valid && dout.last_char))
		else $error("final digit not flagged as last");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.char_code == CHAR_MINUS) |-> !dout.last_char)
		else $error("sign character flagged as last");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for signed_integer_to_base_digits: directed table, then random values in phases
// of different radix, each character checked against table text or a local text predictor.
// Depends on sibd_pkg, sibd_in_if, sibd_out_if and the block's RTL.

module tb;
	import sibd_pkg::*;

	localparam int VALUE_BITS  = VALUE_BITS_DEF;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE      = 4;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 39;
	localparam int ROWS        = 25;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	typedef struct {
		logic [RADIX_W-1:0]    radix;
		logic [VALUE_BITS-1:0] value;
		string                 text;
	} text_row_t;

	// empty text: expected characters come from the predictor
	text_row_t text_rows [ROWS] = '{
		'{5'd10, 32'h0000_0000, "0"},
		'{5'd10, 32'h7FFF_FFFF, "2147483647"},
		'{5'd10, 32'h8000_0000, "-2147483648"},
		'{5'd10, 32'hFFFF_FFFF, "-1"},
		'{5'd10, 32'h0000_0009, "9"},
		'{5'd10, 32'h0000_000A, "10"},
		'{5'd10, 32'h0001_E240, ""},
		'{5'd16, 32'h7FFF_FFFF, "7FFFFFFF"},
		'{5'd16, 32'h8000_0000, "-80000000"},
		'{5'd16, 32'h00AB_CDEF, "ABCDEF"},
		'{5'd16, 32'hFFFF_FF01, "-FF"},
		'{5'd2,  32'h8000_0000, ""},
		'{5'd2,  32'h7FFF_FFFF, ""},
		'{5'd2,  32'h0000_0000, "0"},
		'{5'd0,  32'h0000_0005, "101"},
		'{5'd1,  32'hFFFF_FFFA, "-110"},
		'{5'd17, 32'h0000_00FF, "FF"},
		'{5'd31, 32'h8000_0000, "-80000000"},
		'{5'd3,  32'h8000_0000, ""},
		'{5'd7,  32'h0000_3039, ""},
		'{5'd15, 32'hFFF0_BDC0, ""},
		'{5'd8,  32'h8000_0000, "-20000000000"},
		'{5'd4,  32'h5555_5555, ""},
		'{5'd9,  32'h8000_0001, ""},
		'{5'd10, 32'h0000_0001, "1"}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [RADIX_W-1:0] cfg_wdata;

	sibd_in_if #(.VALUE_BITS(VALUE_BITS)) din_if ();
	sibd_out_if dout_if ();

	signed_integer_to_base_digits #(.VALUE_BITS(VALUE_BITS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	text_char_t         pending_text [$];
	logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;
	bit                 tx_idle_on = 1'b1;
	bit                 rx_idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] base;
		logic [DIGIT_W-1:0]    digits [$];
		text_char_t            c;
		if (cur_radix < RADIX_MIN) base = VALUE_BITS'(RADIX_MIN);
		else if (cur_radix > RADIX_MAX) base = VALUE_BITS'(RADIX_MAX);
		else base = VALUE_BITS'(cur_radix);
		mag = v[VALUE_BITS-1] ? ~v + 1'b1 : v;
		do begin
			digits.push_front(DIGIT_W'(mag % base));
			mag = mag / base;
		end while (mag != 0);
		if (v[VALUE_BITS-1]) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			pending_text.push_back(c);
		end
		foreach (digits[i]) begin
			c.code = (digits[i] < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(digits[i])
				: CHAR_ALPHA + CHAR_W'(digits[i]);
			c.last = (i == digits.size() - 1);
			pending_text.push_back(c);
		end
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $time, msg);
	endtask

	task automatic send_value(input logic [VALUE_BITS-1:0] v, input string text);
		int unsigned gap;
		text_char_t  c;
		gap = tx_idle_on ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= v;
		do @(posedge clk); while (!din_if.ready);
		if (text.len() == 0) begin
			predict_text(v);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				c.code = text[i];
				c.last = (i == text.len() - 1);
				pending_text.push_back(c);
			end
		end
	endtask

	task automatic drain_results();
		din_if.valid <= 1'b0;
		while (pending_text.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_radix = r;
	endtask

	// output side: random stall before each request, then check it
	initial begin
		text_char_t  want;
		int unsigned stall;
		dout_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 18) : 0;
			if (stall != 0) begin
				dout_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_if.ready <= 1'b1;
			do @(posedge clk); while (!dout_if.valid);
			if (pending_text.size() == 0) begin
				note_failure($sformatf("unexpected char %h last %b",
					dout_if.char_code, dout_if.last_char));
			end else begin
				want = pending_text.pop_front();
				if (dout_if.char_code !== want.code || dout_if.last_char !== want.last)
					note_failure($sformatf("expected char %h last %b, got char %h last %b",
						want.code, want.last, dout_if.char_code, dout_if.last_char));
			end
		end
	end

	initial begin
		logic [RADIX_W-1:0]    phase_radix [8];
		logic [VALUE_BITS-1:0] v;
		int unsigned           kind;
		phase_radix = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd1, 5'd17, 5'd8};
		arst_n        <= 1'b0;
		din_if.valid  <= 1'b0;
		din_if.value  <= '0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; first rows run on the reset radix
		foreach (text_rows[i]) begin
			if (text_rows[i].radix != cur_radix) set_radix(text_rows[i].radix);
			send_value(text_rows[i].value, text_rows[i].text);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_radix(p < 8 ? phase_radix[p] : RADIX_W'($urandom_range(0, 31)));
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == 20) drain_results();
				kind = $urandom_range(0, 9);
				case (kind)
					0: begin
						case ($urandom_range(0, 3))
							0: v = '0;
							1: v = '1;
							2: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
							default: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
						endcase
					end
					1, 2, 3: v = $urandom;
					default: begin
						v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
						if ($urandom_range(0, 1) != 0) v = ~v + 1'b1;
					end
				endcase
				send_value(v, "");
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (pending_text.size() != 0) note_failure("characters still outstanding");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sibd_pkg.sv
rtl/sibd_in_if.sv
rtl/sibd_out_if.sv
rtl/sibd_div.sv
rtl/signed_integer_to_base_digits.sv
verif/tb.sv
